// File: hw/rtl/bps_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the Bezier patch subdivider.
// Used by the channel interfaces, the divider, the interpolator and the top level.
package bps_pkg;

	// Largest patch degree along u or v, and the control point store depth.
	localparam int MAX_DEG    = 3;
	localparam int PT_DEPTH   = (MAX_DEG + 1) * (MAX_DEG + 1);
	localparam int PT_AW      = $clog2(PT_DEPTH);
	localparam int DEG_BITS   = 2;
	// Parameter registers are Q16.16; the split weight is unsigned Q0.16.
	localparam int REG_BITS   = 32;
	localparam int FRAC_BITS  = 16;
	localparam int CFG_IDX_BITS = 3;

	typedef logic [DEG_BITS-1:0]     deg_t;
	typedef logic [PT_AW-1:0]        pt_addr_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	typedef logic [FRAC_BITS-1:0]    weight_t;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_DEGREE_U = 3'd0;
	localparam cfg_idx_t CFG_DEGREE_V = 3'd1;
	localparam cfg_idx_t CFG_SPLIT_DIR = 3'd2;
	localparam cfg_idx_t CFG_SPLIT_AT = 3'd3;
	localparam cfg_idx_t CFG_U_LOW    = 3'd4;
	localparam cfg_idx_t CFG_U_HIGH   = 3'd5;
	localparam cfg_idx_t CFG_V_LOW    = 3'd6;
	localparam cfg_idx_t CFG_V_HIGH   = 3'd7;

	// Store position of control point (i, j) for a patch of degree q along v.
	function automatic pt_addr_t pt_addr(input deg_t i, input deg_t j, input deg_t q);
		logic [PT_AW-1:0] r;
		r = PT_AW'(i) * (PT_AW'(q) + PT_AW'(1)) + PT_AW'(j);
		return r;
	endfunction

endpackage

// File: hw/rtl/bps_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: control points in, result points out, register writes.
// Depends on bps_pkg for register widths.
interface bps_pt_if #(parameter int COORD_BITS = 32);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] px;
	logic [COORD_BITS-1:0] py;
	logic [COORD_BITS-1:0] pz;
	logic [COORD_BITS-1:0] pw;
	logic                  final_point;
	modport source (output valid, px, py, pz, pw, final_point, input ready);
	modport sink (input valid, px, py, pz, pw, final_point, output ready);
endinterface

interface bps_res_if #(parameter int COORD_BITS = 32);
	logic                  valid;
	logic                  ready;
	logic                  half;
	logic [1:0]            u_index;
	logic [1:0]            v_index;
	logic [COORD_BITS-1:0] qx;
	logic [COORD_BITS-1:0] qy;
	logic [COORD_BITS-1:0] qz;
	logic [COORD_BITS-1:0] qw;
	logic                  split_outside;
	logic                  end_of_run;
	modport source (output valid, half, u_index, v_index, qx, qy, qz, qw, split_outside,
		end_of_run, input ready);
	modport sink (input valid, half, u_index, v_index, qx, qy, qz, qw, split_outside,
		end_of_run, output ready);
endinterface

interface bps_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bps_pkg::CFG_IDX_BITS-1:0] index;
	logic [bps_pkg::REG_BITS-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/bps_div.sv
`timescale 1ns / 1ps
// Serial restoring divider producing the Q0.16 split weight, one quotient bit per cycle.
// Depends on bps_pkg for register and fraction widths.
module bps_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bps_pkg::REG_BITS-1:0]  num,
	input  logic [bps_pkg::REG_BITS-1:0]  den,
	output logic                          done,
	output logic [bps_pkg::FRAC_BITS-1:0] quo
);
	import bps_pkg::*;

	localparam int CNT_BITS = $clog2(FRAC_BITS);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [REG_BITS-1:0]   rem_q;
	logic [REG_BITS-1:0]   den_q;
	logic [FRAC_BITS-1:0]  quo_q;
	logic [REG_BITS:0]     rem2;
	logic                  ge;

	// Shift the remainder left and try to subtract the divisor.
	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};

	// Control: busy while the quotient bits are shifted in, then a one-cycle done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the numerator is below the divisor, so the remainder stays in range.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? REG_BITS'(rem2 - {1'b0, den_q}) : rem2[REG_BITS-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: hw/rtl/bps_lerp.sv
`timescale 1ns / 1ps
// Shared interpolation unit: b + floor(alpha * (a - b)) on four coordinates, one multiplier.
// Depends on bps_pkg for the weight width.
module bps_lerp #(
	parameter int CW = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bps_pkg::FRAC_BITS-1:0] alpha,
	input  logic [4*CW-1:0]               a,
	input  logic [4*CW-1:0]               b,
	output logic                          done,
	output logic [4*CW-1:0]               res
);
	import bps_pkg::*;

	localparam int PW = CW + FRAC_BITS + 2;

	logic                 busy_q;
	logic                 done_q;
	logic                 mul_ph_q;
	logic [1:0]           c_q;
	logic signed [PW-1:0] prod_q;
	logic [4*CW-1:0]      res_q;
	logic [CW-1:0]        a_c;
	logic [CW-1:0]        b_c;
	logic signed [CW:0]   diff;

	// Coordinate select and difference.
	assign a_c  = a[c_q*CW +: CW];
	assign b_c  = b[c_q*CW +: CW];
	assign diff = $signed({a_c[CW-1], a_c}) - $signed({b_c[CW-1], b_c});

	// Per coordinate: multiply, then shift and add.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			mul_ph_q <= 1'b0;
			c_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				mul_ph_q <= 1'b0;
				c_q      <= '0;
			end else if (busy_q) begin
				mul_ph_q <= !mul_ph_q;
				if (mul_ph_q) begin
					c_q <= c_q + 2'd1;
					if (c_q == 2'd3) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// The arithmetic shift of the product is the floor; the sum always fits in CW bits.
	always_ff @(posedge clk) begin
		if (busy_q && !mul_ph_q)
			prod_q <= $signed({1'b0, alpha}) * diff;
		if (busy_q && mul_ph_q)
			res_q[c_q*CW +: CW] <= b_c + prod_q[FRAC_BITS +: CW];
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: hw/rtl/bezier_patch_subdivide.sv
`timescale 1ns / 1ps
// Bezier patch subdivision by de Casteljau interpolation, Q16.16 homogeneous points.
// Loading takes one point per cycle. After the final point come setup, the divider,
// then per line the moves plus L*(L+1)/2 interpolations, with L the degree split.
// A split outside the range goes straight to output; each point is held until taken.
// Reset presets config, sequencer and load count; the point stores start undefined.
module bezier_patch_subdivide #(
	parameter int COORD_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	bps_pt_if.sink           points,
	bps_res_if.source        results,
	bps_cfg_if.sink          cfg
);
	import bps_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int LCW = PT_AW + 1;

	// Sequencer states.
	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_SETUP = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_RDW   = 4'd4;
	localparam logic [3:0] S_WRL   = 4'd5;
	localparam logic [3:0] S_WRR   = 4'd6;
	localparam logic [3:0] S_LRP   = 4'd7;
	localparam logic [3:0] S_LWT   = 4'd8;
	localparam logic [3:0] S_EMRD  = 4'd9;
	localparam logic [3:0] S_EMOUT = 4'd10;

	// Configuration registers.
	deg_t                  deg_u_q, deg_v_q;
	logic                  dir_q;
	logic [REG_BITS-1:0]   split_q, u_low_q, u_high_q, v_low_q, v_high_q;

	logic [3:0]            state_q;
	logic [LCW-1:0]        load_cnt_q;
	weight_t               alpha_q;
	logic                  outside_q;
	deg_t                  line_q, m_q, k_q;
	logic                  eh_q;
	deg_t                  ei_q, ej_q;

	logic [4*CW-1:0]       net_mem [PT_DEPTH];
	logic [4*CW-1:0]       out_mem [2*PT_DEPTH];
	logic [4*CW-1:0]       net_rd_q;
	logic [4*CW-1:0]       out_rd_q;
	logic [4*CW-1:0]       w_q [MAX_DEG+1];
	logic [4*CW-1:0]       prev_q;

	logic                  in_acc, out_acc;
	logic signed [REG_BITS-1:0] lo, hi, sp;
	logic                  outside;
	logic [REG_BITS:0]     num_w, den_w;
	logic                  div_start, div_done;
	weight_t               div_quo;
	logic                  lerp_start, lerp_done;
	logic [4*CW-1:0]       lerp_res;
	deg_t                  len, last_line;
	deg_t                  rd_idx, wr_idx;
	pt_addr_t              rd_addr, wr_addr, em_addr;
	logic                  wr_en;
	logic [4*CW-1:0]       wr_data;
	logic                  em_last;

	assign in_acc  = points.valid && points.ready;
	assign out_acc = results.valid && results.ready;
	assign cfg.ready = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_u_q  <= 2'd3;
			deg_v_q  <= 2'd3;
			dir_q    <= 1'b0;
			split_q  <= '0;
			u_low_q  <= '0;
			u_high_q <= REG_BITS'(65536);
			v_low_q  <= '0;
			v_high_q <= REG_BITS'(65536);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_DEGREE_U:  deg_u_q  <= cfg.data[DEG_BITS-1:0];
				CFG_DEGREE_V:  deg_v_q  <= cfg.data[DEG_BITS-1:0];
				CFG_SPLIT_DIR: dir_q    <= cfg.data[0];
				CFG_SPLIT_AT:  split_q  <= cfg.data;
				CFG_U_LOW:     u_low_q  <= cfg.data;
				CFG_U_HIGH:    u_high_q <= cfg.data;
				CFG_V_LOW:     v_low_q  <= cfg.data;
				CFG_V_HIGH:    v_high_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Split range check and divider operands.
	assign lo      = dir_q ? v_low_q : u_low_q;
	assign hi      = dir_q ? v_high_q : u_high_q;
	assign sp      = split_q;
	assign outside = !((lo < sp) && (sp < hi));
	assign num_w   = {sp[REG_BITS-1], sp} - {lo[REG_BITS-1], lo};
	assign den_w   = {hi[REG_BITS-1], hi} - {lo[REG_BITS-1], lo};
	assign div_start = (state_q == S_SETUP) && !outside;

	bps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_w[REG_BITS-1:0]),
		.den    (den_w[REG_BITS-1:0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign lerp_start = (state_q == S_LRP);

	bps_lerp #(.CW(CW)) u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.alpha  (alpha_q),
		.a      (w_q[m_q]),
		.b      (prev_q),
		.done   (lerp_done),
		.res    (lerp_res)
	);

	// Line geometry: a line runs along the split direction.
	assign len       = dir_q ? deg_v_q : deg_u_q;
	assign last_line = dir_q ? deg_u_q : deg_v_q;
	assign rd_idx    = m_q;
	assign wr_idx    = (state_q == S_WRL) ? k_q : 2'(len - k_q);
	assign rd_addr   = dir_q ? pt_addr(line_q, rd_idx, deg_v_q) : pt_addr(rd_idx, line_q, deg_v_q);
	assign wr_addr   = dir_q ? pt_addr(line_q, wr_idx, deg_v_q) : pt_addr(wr_idx, line_q, deg_v_q);
	assign em_addr   = pt_addr(ei_q, ej_q, deg_v_q);
	assign wr_en     = (state_q == S_WRL) || (state_q == S_WRR);
	assign wr_data   = (state_q == S_WRL) ? w_q[k_q] : w_q[len];
	assign em_last   = eh_q && (ei_q == deg_u_q) && (ej_q == deg_v_q);

	// Point stores.
	always_ff @(posedge clk) begin
		if (in_acc && !load_cnt_q[PT_AW])
			net_mem[load_cnt_q[PT_AW-1:0]] <= {points.pw, points.pz, points.py, points.px};
		if (state_q == S_RD)
			net_rd_q <= net_mem[rd_addr];
		if (wr_en)
			out_mem[{state_q == S_WRR, wr_addr}] <= wr_data;
		if (state_q == S_EMRD)
			out_rd_q <= out_mem[{eh_q, em_addr}];
	end

	// Working line registers.
	always_ff @(posedge clk) begin
		if (state_q == S_RDW)
			w_q[m_q] <= net_rd_q;
		if (state_q == S_WRR && k_q != len)
			prev_q <= w_q[k_q];
		if (state_q == S_LWT && lerp_done) begin
			w_q[m_q] <= lerp_res;
			prev_q   <= w_q[m_q];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			load_cnt_q <= '0;
			alpha_q    <= '0;
			outside_q  <= 1'b0;
			line_q     <= '0;
			m_q        <= '0;
			k_q        <= '0;
			eh_q       <= 1'b0;
			ei_q       <= '0;
			ej_q       <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (points.final_point) begin
							load_cnt_q <= '0;
							state_q    <= S_SETUP;
						end else if (!load_cnt_q[PT_AW]) begin
							load_cnt_q <= load_cnt_q + LCW'(1);
						end
					end
				end
				S_SETUP: begin
					outside_q <= outside;
					eh_q      <= 1'b0;
					ei_q      <= '0;
					ej_q      <= '0;
					line_q    <= '0;
					m_q       <= '0;
					state_q   <= outside ? S_EMRD : S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						alpha_q <= div_quo;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					if (m_q == len) begin
						k_q     <= '0;
						state_q <= S_WRL;
					end else begin
						m_q     <= m_q + 2'd1;
						state_q <= S_RD;
					end
				end
				S_WRL: state_q <= S_WRR;
				S_WRR: begin
					if (k_q == len) begin
						if (line_q == last_line) begin
							state_q <= S_EMRD;
						end else begin
							line_q  <= line_q + 2'd1;
							m_q     <= '0;
							state_q <= S_RD;
						end
					end else begin
						k_q     <= k_q + 2'd1;
						m_q     <= k_q + 2'd1;
						state_q <= S_LRP;
					end
				end
				S_LRP: state_q <= S_LWT;
				S_LWT: begin
					if (lerp_done) begin
						if (m_q == len) begin
							state_q <= S_WRL;
						end else begin
							m_q     <= m_q + 2'd1;
							state_q <= S_LRP;
						end
					end
				end
				S_EMRD: state_q <= S_EMOUT;
				S_EMOUT: begin
					if (out_acc) begin
						state_q <= em_last ? S_LOAD : S_EMRD;
						if (ej_q != deg_v_q) begin
							ej_q <= ej_q + 2'd1;
						end else begin
							ej_q <= '0;
							if (ei_q != deg_u_q) begin
								ei_q <= ei_q + 2'd1;
							end else begin
								ei_q <= '0;
								eh_q <= 1'b1;
							end
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Handshakes and result beat.
	assign points.ready          = (state_q == S_LOAD);
	assign results.valid         = (state_q == S_EMOUT);
	assign results.half          = eh_q;
	assign results.u_index       = ei_q;
	assign results.v_index       = ej_q;
	assign results.qx            = outside_q ? '0 : out_rd_q[0*CW +: CW];
	assign results.qy            = outside_q ? '0 : out_rd_q[1*CW +: CW];
	assign results.qz            = outside_q ? '0 : out_rd_q[2*CW +: CW];
	assign results.qw            = outside_q ? '0 : out_rd_q[3*CW +: CW];
	assign results.split_outside = outside_q;
	assign results.end_of_run    = em_last;

	// Loading and emitting never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !points.ready)
		else $error("input ready while a result beat is offered");

	// The final point closes loading until the run has been emitted.
	a_final_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && points.final_point) |=> !points.ready)
		else $error("input still ready after the final point");

	// The load count saturates at the store depth.
	a_load_sat: assert property (@(posedge clk) disable iff (!arst_n)
		load_cnt_q <= LCW'(PT_DEPTH))
		else $error("load count beyond store depth");

	// The interpolator only finishes while the sequencer waits for it.
	a_lerp_wait: assert property (@(posedge clk) disable iff (!arst_n)
		lerp_done |-> (state_q == S_LWT))
		else $error("interpolation finished outside its wait state");

endmodule
